/* hdl/gfr_pkg.sv */
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types and constants of the GF(2) form reducer.
// ----------------------------------------------------------------------------
package gfr_pkg;

  localparam int IDX_W      = 6;
  localparam int FORM_PORT_W = 64;
  localparam int LVL_PORT_W = 16;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_REDUCE = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // control part of a beat moving along the cell chain
  typedef struct packed {
    logic             vld;
    logic             cmd;
    logic [IDX_W-1:0] idx;
    logic             status;
    logic             clr;
    logic             changed;
  } beat_ctl_t;

endpackage

/* hdl/gfr_if.sv */
// ----------------------------------------------------------------------------
// gfr_if
// Valid/ready channels of the GF(2) form reducer: command in, result out.
// ----------------------------------------------------------------------------
interface gfr_in_if
  import gfr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [IDX_W-1:0]       var_index;
  logic [FORM_PORT_W-1:0] form_bits;
  logic [LVL_PORT_W-1:0]  level;

  modport source (output valid, cmd, var_index, form_bits, level, input ready);
  modport sink   (input valid, cmd, var_index, form_bits, level, output ready);
endinterface

interface gfr_out_if
  import gfr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [FORM_PORT_W-1:0] result_form;
  logic                   changed;
  logic                   status;

  modport source (output valid, result_form, changed, status, input ready);
  modport sink   (input valid, result_form, changed, status, output ready);
endinterface

/* hdl/gfr_entry.sv */
// ----------------------------------------------------------------------------
// gfr_entry
// Head stage: masks the form, checks a row write and launches the beat.
// ----------------------------------------------------------------------------
module gfr_entry
  import gfr_pkg::*;
#(
  parameter int VAR_COUNT  = 63,
  parameter int LEVEL_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  input  logic [IDX_W-1:0]       in_var_index,
  input  logic [FORM_PORT_W-1:0] in_form_bits,
  input  logic [LVL_PORT_W-1:0]  in_level,
  output beat_ctl_t              beat_ctl_r,
  output logic [VAR_COUNT:0]     beat_form_r,
  output logic [LEVEL_BITS-1:0]  beat_lvl_r
);

  localparam int FW = VAR_COUNT + 1;

  logic [FW-1:0]  form_m;
  logic [FW-1:0]  lead_bit;
  logic [FW-1:0]  low_mask;
  logic           idx_bad;
  logic           vars_zero;
  logic           lead_ok;
  beat_ctl_t      beat_ctl_nxt;

  always_comb begin
    form_m    = in_form_bits[VAR_COUNT:0];
    vars_zero = (form_m[FW-1:1] == '0);
    idx_bad   = (in_var_index == '0) || (in_var_index > IDX_W'(VAR_COUNT));
    lead_bit  = FW'(1) << in_var_index;
    // variables 1..idx; the subtraction wraps to all ones when idx is the top variable
    low_mask  = ((lead_bit << 1) - FW'(1)) & ~FW'(1);
    lead_ok   = ((form_m & low_mask) == lead_bit);

    beat_ctl_nxt.vld     = in_valid;
    beat_ctl_nxt.cmd     = in_cmd;
    beat_ctl_nxt.idx     = in_var_index;
    beat_ctl_nxt.clr     = vars_zero;
    beat_ctl_nxt.changed = 1'b0;
    if (in_cmd == CMD_WRITE && (idx_bad || (!vars_zero && !lead_ok))) begin
      beat_ctl_nxt.status = STATUS_REJECTED;
    end else begin
      beat_ctl_nxt.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      beat_ctl_r.vld <= beat_ctl_nxt.vld;
    end
    if (adv) begin
      beat_ctl_r.cmd     <= beat_ctl_nxt.cmd;
      beat_ctl_r.idx     <= beat_ctl_nxt.idx;
      beat_ctl_r.status  <= beat_ctl_nxt.status;
      beat_ctl_r.clr     <= beat_ctl_nxt.clr;
      beat_ctl_r.changed <= beat_ctl_nxt.changed;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_form_r        <= form_m;
      beat_lvl_r         <= LEVEL_BITS'(in_level);
    end
  end

endmodule

/* hdl/gfr_cell.sv */
// ----------------------------------------------------------------------------
// gfr_cell
// One chain cell: holds the table row of one leading variable, applies it
// to a passing reduce beat or takes it from a passing write beat.
// ----------------------------------------------------------------------------
module gfr_cell
  import gfr_pkg::*;
#(
  parameter int VAR_COUNT  = 63,
  parameter int LEVEL_BITS = 16,
  parameter int VAR_POS    = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  beat_ctl_t             prev_ctl,
  input  logic [VAR_COUNT:0]    prev_form,
  input  logic [LEVEL_BITS-1:0] prev_lvl,
  output beat_ctl_t             beat_ctl_r,
  output logic [VAR_COUNT:0]    beat_form_r,
  output logic [LEVEL_BITS-1:0] beat_lvl_r
);

  logic [VAR_COUNT:0]    row_form_r;
  logic [LEVEL_BITS-1:0] row_lvl_r;
  logic                  row_vld_r;

  logic                  hit;
  logic                  wr_mine;
  beat_ctl_t             beat_ctl_nxt;
  logic [VAR_COUNT:0]    beat_form_nxt;

  always_comb begin
    hit = prev_ctl.vld && (prev_ctl.cmd == CMD_REDUCE) && prev_form[VAR_POS]
          && row_vld_r && (row_lvl_r <= prev_lvl);
    wr_mine = prev_ctl.vld && (prev_ctl.cmd == CMD_WRITE)
              && (prev_ctl.idx == IDX_W'(VAR_POS)) && (prev_ctl.status == STATUS_OK);

    beat_ctl_nxt  = prev_ctl;
    beat_form_nxt = prev_form;
    if (hit) begin
      beat_form_nxt        = prev_form ^ row_form_r;
      beat_ctl_nxt.changed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r      <= 1'b0;
      beat_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      beat_ctl_r.vld <= beat_ctl_nxt.vld;
      if (wr_mine) begin
        row_vld_r <= !prev_ctl.clr;
      end
    end
    if (adv) begin
      beat_ctl_r.cmd     <= beat_ctl_nxt.cmd;
      beat_ctl_r.idx     <= beat_ctl_nxt.idx;
      beat_ctl_r.status  <= beat_ctl_nxt.status;
      beat_ctl_r.clr     <= beat_ctl_nxt.clr;
      beat_ctl_r.changed <= beat_ctl_nxt.changed;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_form_r        <= beat_form_nxt;
      beat_lvl_r         <= prev_lvl;
      if (wr_mine && !prev_ctl.clr) begin
        row_form_r <= prev_form;
        row_lvl_r  <= prev_lvl;
      end
    end
  end

endmodule

/* hdl/gf2_form_assignment_reducer_top.sv */
// ----------------------------------------------------------------------------
// gf2_form_assignment_reducer_top
// GF(2) linear-form reducer with a level-tagged row table kept in a chain
// of cells, one cell per leading variable.
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | handshake
//  in_ch   | in  | cmd, var_index, form_bits, level      | valid / ready
//  out_ch  | out | result_form, changed, status          | valid / ready
//
//  each beat runs through an entry stage and VAR_COUNT cells, one per cycle unless the chain holds
//  the chain is pipelined, so one beat per cycle is taken while results drain, unless a result waits on out_ch.ready
//  writes and reduces stay in order since they travel the same chain
//  the whole chain holds while a result waits on out_ch.ready
//  reset empties the table at once (row valid bits), no clearing pass
// ----------------------------------------------------------------------------
module gf2_form_assignment_reducer_top
  import gfr_pkg::*;
#(
  parameter int VAR_COUNT  = 63,
  parameter int LEVEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  gfr_in_if.sink    in_ch,
  gfr_out_if.source out_ch
);

  beat_ctl_t             ctl_chain  [VAR_COUNT+1];
  logic [VAR_COUNT:0]    form_chain [VAR_COUNT+1];
  logic [LEVEL_BITS-1:0] lvl_chain  [VAR_COUNT+1];
  logic                  adv;

  // last cell's register doubles as the output register
  assign adv         = !ctl_chain[VAR_COUNT].vld || out_ch.ready;
  assign in_ch.ready = adv;

  gfr_entry #(
    .VAR_COUNT  (VAR_COUNT),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_entry (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_ch.valid),
    .in_cmd       (in_ch.cmd),
    .in_var_index (in_ch.var_index),
    .in_form_bits (in_ch.form_bits),
    .in_level     (in_ch.level),
    .beat_ctl_r   (ctl_chain[0]),
    .beat_form_r  (form_chain[0]),
    .beat_lvl_r   (lvl_chain[0])
  );

  for (genvar v = 1; v <= VAR_COUNT; v++) begin : g_cell
    gfr_cell #(
      .VAR_COUNT  (VAR_COUNT),
      .LEVEL_BITS (LEVEL_BITS),
      .VAR_POS    (v)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .prev_ctl    (ctl_chain[v-1]),
      .prev_form   (form_chain[v-1]),
      .prev_lvl    (lvl_chain[v-1]),
      .beat_ctl_r  (ctl_chain[v]),
      .beat_form_r (form_chain[v]),
      .beat_lvl_r  (lvl_chain[v])
    );
  end

  always_comb begin
    out_ch.valid = ctl_chain[VAR_COUNT].vld;
    if (ctl_chain[VAR_COUNT].cmd == CMD_REDUCE) begin
      out_ch.result_form = FORM_PORT_W'(form_chain[VAR_COUNT]);
      out_ch.changed     = ctl_chain[VAR_COUNT].changed;
      out_ch.status      = STATUS_OK;
    end else begin
      out_ch.result_form = '0;
      out_ch.changed     = 1'b0;
      out_ch.status      = ctl_chain[VAR_COUNT].status;
    end
  end

endmodule

/* hdl/gfr_checker.sv */
// ----------------------------------------------------------------------------
// gfr_checker
// Port-level checks of the GF(2) form reducer, bound to the top level.
// ----------------------------------------------------------------------------
module gfr_checker
  import gfr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [FORM_PORT_W-1:0] out_result_form,
  input logic                   out_changed,
  input logic                   out_status
);

  // a result beat is held until taken
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_form) && $stable(out_changed)
                                && $stable(out_status))
    else $error("result payload changed while stalled");

  // empty output stage never blocks the input
  a_in_open : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with output empty");

  // rejected writes carry no form and no change
  a_reject_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_REJECTED) |-> (out_result_form == '0) && !out_changed)
    else $error("rejected write carries payload");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gf2_form_assignment_reducer_top gfr_checker u_gfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_form (out_ch.result_form),
  .out_changed     (out_ch.changed),
  .out_status      (out_ch.status)
);
